### src/ffha_pkg.sv
package ffha_pkg;

    // Width of every address and size field on the ports.
    localparam int FIELD_W = 9;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOMEM   = 2'd1,
        STATUS_BADFREE = 2'd2
    } status_t;

    // The shared unit either adds a + b + header or forms a - b - header.
    typedef enum logic {
        UNIT_ADD_HDR = 1'b0,
        UNIT_SUB_HDR = 1'b1
    } unit_op_t;

endpackage

### src/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/ffha_unit.sv
module ffha_unit #(
    parameter int VW  = 9,
    parameter int HDR = 16
) (
    input  ffha_pkg::unit_op_t op,
    input  logic [VW-1:0]      a,
    input  logic [VW-1:0]      b,
    output logic [VW+1:0]      res
);

    localparam int UW = VW + 2;

    logic [UW-1:0] ax;
    logic [UW-1:0] bx;
    logic [UW-1:0] hx;

    assign ax = UW'(a);
    assign bx = UW'(b);
    assign hx = UW'(HDR);

    // Two extra bits keep the sum exact; the top bit is the sign of a difference.
    always_comb begin
        case (op)
            ffha_pkg::UNIT_ADD_HDR: res = ax + bx + hx;
            ffha_pkg::UNIT_SUB_HDR: res = ax - bx - hx;
            default:                res = ax + bx + hx;
        endcase
    end

endmodule

### src/first_fit_heap_allocator_core.sv
// Channel  | Ports                                        | Direction
// request  | s_valid s_ready s_op s_alloc_size s_free_offset | in
// response | m_valid m_ready m_status m_payload_offset m_freed_size | out
//
// One request at a time; s_ready is high only while idle. The table sits in a RAM with a
// registered read and is walked one entry per cycle through the shared add/subtract unit.
// An allocate scans to the first free entry that fits, moves the entries behind it up and writes
// the split; a free scans to its block and then repacks the whole table; a miss scans every entry.
// An allocate on a full table answers without a scan. The cycle after reset writes the first free block.
// A response held by m_ready low stalls only the next response, not the next request.
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES   = 512,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_BLOCKS   = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [8:0] s_alloc_size,
    input  logic [8:0] s_free_offset,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [8:0] m_payload_offset,
    output logic [8:0] m_freed_size
);

    localparam int FW   = ffha_pkg::FIELD_W;
    localparam int SW   = $clog2(HEAP_BYTES);
    localparam int VW   = (SW > FW) ? SW : FW;
    localparam int UW   = VW + 2;
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);

    typedef struct packed {
        logic [SW-1:0] start;
        logic [SW-1:0] bytes;
        logic          free;
    } entry_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_A_NEW,
        ST_A_GRANT,
        ST_A_SHIFT,
        ST_A_WR_HI,
        ST_A_WR_LO,
        ST_F_PACK,
        ST_F_FLUSH,
        ST_RESP
    } state_t;

    state_t                   state_reg, state_next;
    logic                     op_reg, op_next;
    logic [FW-1:0]            want_reg, want_next;
    logic [FW-1:0]            where_reg, where_next;
    logic [CNTW-1:0]          count_reg, count_next;
    logic [CNTW-1:0]          scan_idx_reg, scan_idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IW-1:0]            rd_idx_reg, rd_idx_next;
    logic [IW-1:0]            hit_idx_reg, hit_idx_next;
    logic [SW-1:0]            hit_start_reg, hit_start_next;
    logic [SW-1:0]            rem_reg, rem_next;
    logic [SW-1:0]            new_start_reg, new_start_next;
    logic [IW-1:0]            src_reg, src_next;
    logic                     cp_vld_reg, cp_vld_next;
    logic [IW-1:0]            cp_idx_reg, cp_idx_next;
    logic                     p_vld_reg, p_vld_next;
    entry_t                   p_reg, p_next;
    logic [IW-1:0]            wr_idx_reg, wr_idx_next;
    ffha_pkg::status_t        status_reg, status_next;
    logic [FW-1:0]            granted_reg, granted_next;
    logic [FW-1:0]            freed_reg, freed_next;
    logic                     m_valid_reg, m_valid_next;
    ffha_pkg::status_t        m_status_reg, m_status_next;
    logic [FW-1:0]            m_payload_offset_reg, m_payload_offset_next;
    logic [FW-1:0]            m_freed_size_reg, m_freed_size_next;

    logic                     ram_we;
    logic [IW-1:0]            ram_waddr;
    entry_t                   ram_wdata;
    logic [IW-1:0]            ram_raddr;
    entry_t                   ram_rdata;

    ffha_pkg::unit_op_t       unit_op;
    logic [VW-1:0]            unit_a;
    logic [VW-1:0]            unit_b;
    logic [UW-1:0]            unit_res;

    logic                     scan_more;
    logic                     hit;
    entry_t                   cur;

    ffha_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    ffha_unit #(
        .VW (VW),
        .HDR(HEADER_BYTES)
    ) u_unit (
        .op (unit_op),
        .a  (unit_a),
        .b  (unit_b),
        .res(unit_res)
    );

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_payload_offset = m_payload_offset_reg;
    assign m_freed_size     = m_freed_size_reg;

    assign scan_more = (scan_idx_reg < count_reg);

    // Operand selection for the shared unit.
    always_comb begin
        unit_op = ffha_pkg::UNIT_ADD_HDR;
        unit_a  = '0;
        unit_b  = '0;
        case (state_reg)
            ST_SCAN: begin
                if (op_reg == ffha_pkg::OP_ALLOC) begin
                    unit_op = ffha_pkg::UNIT_SUB_HDR;
                    unit_a  = VW'(ram_rdata.bytes);
                    unit_b  = VW'(want_reg);
                end else begin
                    unit_a = VW'(ram_rdata.start);
                end
            end
            ST_A_NEW: begin
                unit_a = VW'(hit_start_reg);
                unit_b = VW'(want_reg);
            end
            ST_A_GRANT: begin
                unit_a = VW'(hit_start_reg);
            end
            ST_F_PACK: begin
                unit_a = VW'(p_reg.bytes);
                unit_b = VW'(ram_rdata.bytes);
            end
            default: begin
                unit_a = '0;
            end
        endcase
    end

    always_comb begin
        if (op_reg == ffha_pkg::OP_ALLOC) begin
            hit = ram_rdata.free && !unit_res[UW-1];
        end else begin
            hit = !ram_rdata.free && (unit_res == UW'(where_reg));
        end
        cur = ram_rdata;
        if (rd_idx_reg == hit_idx_reg) begin
            cur.free = 1'b1;
        end
    end

    always_comb begin
        state_next            = state_reg;
        op_next               = op_reg;
        want_next             = want_reg;
        where_next            = where_reg;
        count_next            = count_reg;
        scan_idx_next         = scan_idx_reg;
        rd_vld_next           = rd_vld_reg;
        rd_idx_next           = rd_idx_reg;
        hit_idx_next          = hit_idx_reg;
        hit_start_next        = hit_start_reg;
        rem_next              = rem_reg;
        new_start_next        = new_start_reg;
        src_next              = src_reg;
        cp_vld_next           = cp_vld_reg;
        cp_idx_next           = cp_idx_reg;
        p_vld_next            = p_vld_reg;
        p_next                = p_reg;
        wr_idx_next           = wr_idx_reg;
        status_next           = status_reg;
        granted_next          = granted_reg;
        freed_next            = freed_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_status_next         = m_status_reg;
        m_payload_offset_next = m_payload_offset_reg;
        m_freed_size_next     = m_freed_size_reg;
        ram_we                = 1'b0;
        ram_waddr             = '0;
        ram_wdata             = '0;
        ram_raddr             = '0;

        case (state_reg)
            ST_INIT: begin
                ram_we          = 1'b1;
                ram_wdata.start = '0;
                ram_wdata.bytes = SW'(HEAP_BYTES - HEADER_BYTES);
                ram_wdata.free  = 1'b1;
                count_next      = CNTW'(1);
                state_next      = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_op;
                    want_next     = s_alloc_size;
                    where_next    = s_free_offset;
                    scan_idx_next = '0;
                    rd_vld_next   = 1'b0;
                    granted_next  = '0;
                    freed_next    = '0;
                    // A full table cannot take a split, so the answer is known.
                    if (s_op == ffha_pkg::OP_ALLOC && count_reg == CNTW'(MAX_BLOCKS)) begin
                        status_next = ffha_pkg::STATUS_NOMEM;
                        state_next  = ST_RESP;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                ram_raddr = scan_idx_reg[IW-1:0];
                if (scan_more) begin
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CNTW'(1);
                end else begin
                    rd_vld_next = 1'b0;
                end
                if (rd_vld_reg && hit) begin
                    hit_idx_next = rd_idx_reg;
                    if (op_reg == ffha_pkg::OP_ALLOC) begin
                        hit_start_next = ram_rdata.start;
                        rem_next       = unit_res[SW-1:0];
                        state_next     = ST_A_NEW;
                    end else begin
                        freed_next    = FW'(ram_rdata.bytes);
                        status_next   = ffha_pkg::STATUS_OK;
                        scan_idx_next = '0;
                        rd_vld_next   = 1'b0;
                        p_vld_next    = 1'b0;
                        wr_idx_next   = '0;
                        state_next    = ST_F_PACK;
                    end
                end else if (!rd_vld_reg && !scan_more) begin
                    if (op_reg == ffha_pkg::OP_ALLOC) begin
                        status_next = ffha_pkg::STATUS_NOMEM;
                    end else begin
                        status_next = ffha_pkg::STATUS_BADFREE;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_A_NEW: begin
                new_start_next = unit_res[SW-1:0];
                state_next     = ST_A_GRANT;
            end
            ST_A_GRANT: begin
                granted_next = unit_res[FW-1:0];
                src_next     = IW'(count_reg - CNTW'(1));
                cp_vld_next  = 1'b0;
                state_next   = ST_A_SHIFT;
            end
            ST_A_SHIFT: begin
                // Entries behind the split move up by one, highest first; a read
                // issued in one cycle is written one slot higher in the next.
                if (src_reg > hit_idx_reg) begin
                    ram_raddr   = src_reg;
                    cp_vld_next = 1'b1;
                    cp_idx_next = src_reg;
                    src_next    = src_reg - IW'(1);
                end else begin
                    cp_vld_next = 1'b0;
                end
                if (cp_vld_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_idx_reg + IW'(1);
                    ram_wdata = ram_rdata;
                end
                if (!(src_reg > hit_idx_reg) && !cp_vld_reg) begin
                    state_next = ST_A_WR_HI;
                end
            end
            ST_A_WR_HI: begin
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_reg + IW'(1);
                ram_wdata.start = new_start_reg;
                ram_wdata.bytes = rem_reg;
                ram_wdata.free  = 1'b1;
                state_next      = ST_A_WR_LO;
            end
            ST_A_WR_LO: begin
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_reg;
                ram_wdata.start = hit_start_reg;
                ram_wdata.bytes = SW'(want_reg);
                ram_wdata.free  = 1'b0;
                count_next      = count_reg + CNTW'(1);
                status_next     = ffha_pkg::STATUS_OK;
                state_next      = ST_RESP;
            end
            ST_F_PACK: begin
                // Rewrite the table in place, folding each free entry into a
                // free entry held just before it. Writes trail the reads.
                ram_raddr = scan_idx_reg[IW-1:0];
                if (scan_more) begin
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CNTW'(1);
                end else begin
                    rd_vld_next = 1'b0;
                end
                if (rd_vld_reg) begin
                    if (!p_vld_reg) begin
                        p_next     = cur;
                        p_vld_next = 1'b1;
                    end else if (p_reg.free && cur.free) begin
                        p_next.bytes = unit_res[SW-1:0];
                    end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = wr_idx_reg;
                        ram_wdata   = p_reg;
                        wr_idx_next = wr_idx_reg + IW'(1);
                        p_next      = cur;
                    end
                end else if (!scan_more) begin
                    state_next = ST_F_FLUSH;
                end
            end
            ST_F_FLUSH: begin
                ram_we     = 1'b1;
                ram_waddr  = wr_idx_reg;
                ram_wdata  = p_reg;
                count_next = CNTW'(wr_idx_reg) + CNTW'(1);
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_status_next         = status_reg;
                    m_payload_offset_next = granted_reg;
                    m_freed_size_next     = freed_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            count_reg   <= CNTW'(1);
            rd_vld_reg  <= 1'b0;
            cp_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_vld_reg  <= rd_vld_next;
            cp_vld_reg  <= cp_vld_next;
            p_vld_reg   <= p_vld_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg               <= op_next;
        want_reg             <= want_next;
        where_reg            <= where_next;
        scan_idx_reg         <= scan_idx_next;
        rd_idx_reg           <= rd_idx_next;
        hit_idx_reg          <= hit_idx_next;
        hit_start_reg        <= hit_start_next;
        rem_reg              <= rem_next;
        new_start_reg        <= new_start_next;
        src_reg              <= src_next;
        cp_idx_reg           <= cp_idx_next;
        p_reg                <= p_next;
        wr_idx_reg           <= wr_idx_next;
        status_reg           <= status_next;
        granted_reg          <= granted_next;
        freed_reg            <= freed_next;
        m_status_reg         <= m_status_next;
        m_payload_offset_reg <= m_payload_offset_next;
        m_freed_size_reg     <= m_freed_size_next;
    end

endmodule

### tb/first_fit_heap_allocator_core_tb.sv
module first_fit_heap_allocator_core_tb;

    localparam int HEAP_BYTES   = 512;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 32;
    localparam int FIELD_W      = ffha_pkg::FIELD_W;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 600;

    typedef struct {
        ffha_pkg::status_t    status;
        logic [FIELD_W-1:0]   payload_offset;
        logic [FIELD_W-1:0]   freed_size;
    } heap_reply_t;

    // Tracks the block table as the allocator should see it and queues the
    // reply that each accepted request must produce.
    class heap_ledger;
        int unsigned        blk_start [MAX_BLOCKS];
        int unsigned        blk_bytes [MAX_BLOCKS];
        bit                 blk_free  [MAX_BLOCKS];
        int unsigned        blk_count;
        heap_reply_t        pending_replies [$];
        logic [FIELD_W-1:0] live_offsets [$];
        logic [FIELD_W-1:0] stale_offset;
        int unsigned        failures;

        function new();
            blk_start[0] = 0;
            blk_bytes[0] = HEAP_BYTES - HEADER_BYTES;
            blk_free[0]  = 1'b1;
            blk_count    = 1;
            stale_offset = '0;
            failures     = 0;
        endfunction

        function void drop_block(int unsigned idx);
            int unsigned k;
            for (k = idx; k + 1 < blk_count; k++) begin
                blk_start[k] = blk_start[k + 1];
                blk_bytes[k] = blk_bytes[k + 1];
                blk_free[k]  = blk_free[k + 1];
            end
            blk_count--;
        endfunction

        function heap_reply_t predict_reply(logic op, logic [FIELD_W-1:0] size,
                                            logic [FIELD_W-1:0] offset);
            heap_reply_t r;
            int unsigned i;
            int unsigned k;
            bit          found;
            r.status         = ffha_pkg::STATUS_NOMEM;
            r.payload_offset = '0;
            r.freed_size     = '0;
            found            = 1'b0;
            i                = 0;
            if (op == ffha_pkg::OP_ALLOC) begin
                while (i < blk_count && !found) begin
                    if (blk_free[i] && blk_bytes[i] >= size + HEADER_BYTES)
                        found = 1'b1;
                    else
                        i++;
                end
                if (found && blk_count < MAX_BLOCKS) begin
                    for (k = blk_count; k > i + 1; k--) begin
                        blk_start[k] = blk_start[k - 1];
                        blk_bytes[k] = blk_bytes[k - 1];
                        blk_free[k]  = blk_free[k - 1];
                    end
                    blk_start[i + 1] = blk_start[i] + HEADER_BYTES + size;
                    blk_bytes[i + 1] = blk_bytes[i] - size - HEADER_BYTES;
                    blk_free[i + 1]  = 1'b1;
                    blk_bytes[i]     = size;
                    blk_free[i]      = 1'b0;
                    blk_count++;
                    r.status         = ffha_pkg::STATUS_OK;
                    r.payload_offset = FIELD_W'(blk_start[i] + HEADER_BYTES);
                    live_offsets.push_back(r.payload_offset);
                end
            end else begin
                r.status = ffha_pkg::STATUS_BADFREE;
                while (i < blk_count && !found) begin
                    if (!blk_free[i] && blk_start[i] + HEADER_BYTES == offset)
                        found = 1'b1;
                    else
                        i++;
                end
                if (found) begin
                    blk_free[i]  = 1'b1;
                    r.freed_size = FIELD_W'(blk_bytes[i]);
                    r.status     = ffha_pkg::STATUS_OK;
                    // Fold every run of adjacent free blocks into its first block.
                    i = 0;
                    while (i + 1 < blk_count) begin
                        if (blk_free[i] && blk_free[i + 1]) begin
                            blk_bytes[i] = blk_bytes[i] + HEADER_BYTES + blk_bytes[i + 1];
                            drop_block(i + 1);
                        end else begin
                            i++;
                        end
                    end
                    for (k = 0; k < live_offsets.size(); k++) begin
                        if (live_offsets[k] == offset) begin
                            live_offsets.delete(k);
                            break;
                        end
                    end
                    stale_offset = offset;
                end
            end
            return r;
        endfunction

        function void note_request(logic op, logic [FIELD_W-1:0] size,
                                   logic [FIELD_W-1:0] offset);
            pending_replies.push_back(predict_reply(op, size, offset));
        endfunction

        function void check_reply(logic [1:0] status, logic [FIELD_W-1:0] offset,
                                  logic [FIELD_W-1:0] freed);
            heap_reply_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply beat with nothing outstanding: status %0d",
                         $time, status);
                $display("%0t: offset %0d freed %0d", $time, offset, freed);
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                failures++;
            end
            if (offset !== want.payload_offset) begin
                $display("%0t: payload_offset expected %0d actual %0d",
                         $time, want.payload_offset, offset);
                failures++;
            end
            if (freed !== want.freed_size) begin
                $display("%0t: freed_size expected %0d actual %0d",
                         $time, want.freed_size, freed);
                failures++;
            end
        endfunction
    endclass

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic               s_op          = ffha_pkg::OP_ALLOC;
    logic [FIELD_W-1:0] s_alloc_size  = '0;
    logic [FIELD_W-1:0] s_free_offset = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [1:0]         m_status;
    logic [FIELD_W-1:0] m_payload_offset;
    logic [FIELD_W-1:0] m_freed_size;

    bit          calm         = 1'b0;
    bit          hold_replies = 1'b0;
    int unsigned cycle_count  = 0;
    heap_ledger  ledger       = new();

    first_fit_heap_allocator_core #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_alloc_size    (s_alloc_size),
        .s_free_offset   (s_free_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_payload_offset(m_payload_offset),
        .m_freed_size    (m_freed_size)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("first_fit_heap_allocator_core regression: fail");
            $finish;
        end
        if (aresetn && m_valid && m_ready)
            ledger.check_reply(m_status, m_payload_offset, m_freed_size);
    end

    // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
    task automatic send_request(input logic op, input logic [FIELD_W-1:0] size,
                                input logic [FIELD_W-1:0] offset);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_alloc_size  <= size;
        s_free_offset <= offset;
        do @(posedge aclk); while (!s_ready);
        ledger.note_request(op, size, offset);
    endtask

    initial begin : reply_sink
        int unsigned hold;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_replies) begin
                hold         = HOLD_CYCLES;
                hold_replies = 1'b0;
            end else begin
                hold = calm ? 0 : $urandom_range(0, 19);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : request_source
        int unsigned        n;
        int unsigned        pick;
        int unsigned        roll;
        int unsigned        alloc_pct;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] other;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: exact fit, oversize, empty remainder, double and bogus frees.
        send_request(ffha_pkg::OP_ALLOC, 9'd511, 9'h1FF);
        send_request(ffha_pkg::OP_ALLOC, 9'd481, 9'h000);
        send_request(ffha_pkg::OP_ALLOC, 9'd480, 9'h1FF);
        send_request(ffha_pkg::OP_ALLOC, 9'd0,   9'h000);
        send_request(ffha_pkg::OP_FREE,  9'h1FF, 9'd16);
        send_request(ffha_pkg::OP_FREE,  9'h000, 9'd16);
        send_request(ffha_pkg::OP_FREE,  9'h1FF, 9'd0);
        send_request(ffha_pkg::OP_FREE,  9'h000, 9'd511);
        send_request(ffha_pkg::OP_ALLOC, 9'd0,   9'h1FF);
        send_request(ffha_pkg::OP_ALLOC, 9'd100, 9'h000);
        send_request(ffha_pkg::OP_ALLOC, 9'd5,   9'h155);
        send_request(ffha_pkg::OP_FREE,  9'h0AA, 9'd32);
        send_request(ffha_pkg::OP_ALLOC, 9'd50,  9'h0AA);
        send_request(ffha_pkg::OP_FREE,  9'h155, 9'd16);
        send_request(ffha_pkg::OP_FREE,  9'h000, 9'd148);
        send_request(ffha_pkg::OP_FREE,  9'h1FF, 9'd32);
        send_request(ffha_pkg::OP_FREE,  9'h000, 9'd98);
        send_request(ffha_pkg::OP_ALLOC, 9'd0,   9'h000);
        send_request(ffha_pkg::OP_ALLOC, 9'd0,   9'h1FF);
        send_request(ffha_pkg::OP_FREE,  9'h000, 9'd32);
        send_request(ffha_pkg::OP_FREE,  9'h1FF, 9'd16);
        send_request(ffha_pkg::OP_ALLOC, 9'd256, 9'h000);

        // Random: alternating fill-heavy and drain-heavy stretches.
        for (n = 0; n < 1000; n++) begin
            if (n % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == 400)
                hold_replies = 1'b1;
            alloc_pct = ((n / 64) % 2 == 0) ? 60 : 30;
            pick      = $urandom_range(0, 99);
            other     = FIELD_W'($urandom_range(0, 511));
            if (pick < alloc_pct) begin
                roll = $urandom_range(0, 19);
                if (roll < 6)
                    size = FIELD_W'($urandom_range(0, 4));
                else if (roll < 16)
                    size = FIELD_W'($urandom_range(0, 48));
                else if (roll < 19)
                    size = FIELD_W'($urandom_range(0, 200));
                else
                    size = FIELD_W'($urandom_range(0, 511));
                send_request(ffha_pkg::OP_ALLOC, size, other);
            end else if (pick < 88 && ledger.live_offsets.size() > 0) begin
                send_request(ffha_pkg::OP_FREE, other,
                             ledger.live_offsets[$urandom_range(0, ledger.live_offsets.size() - 1)]);
            end else if (pick < 94) begin
                send_request(ffha_pkg::OP_FREE, other, FIELD_W'($urandom_range(0, 511)));
            end else begin
                send_request(ffha_pkg::OP_FREE, other, ledger.stale_offset);
            end
        end
        s_valid <= 1'b0;

        while (ledger.pending_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (ledger.failures == 0)
            $display("first_fit_heap_allocator_core regression: pass");
        else
            $display("first_fit_heap_allocator_core regression: fail");
        $finish;
    end
endmodule

### files.f
src/ffha_pkg.sv
src/ffha_ram.sv
src/ffha_unit.sv
src/first_fit_heap_allocator_core.sv
tb/first_fit_heap_allocator_core_tb.sv
